// File: rtl/core/cmap_pkg.sv
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared widths, codes and types of the piecewise-linear colour map lookup.
// ----------------------------------------------------------------------------
package cmap_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = 4;
  localparam int Q_W     = 17;
  localparam int Q_FRAC  = 16;
  localparam int CNT_W   = 5;
  localparam int QUO_W   = 9;
  localparam int PROD_W  = 2 * Q_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int DIVD_W  = NUM_W + 8;
  localparam int ENTRY_W = 5 * Q_W;

  localparam logic [Q_W-1:0]   Q_ONE   = Q_W'(65536);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENTRIES);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic [Q_W-1:0] pos;
    logic [Q_W-1:0] red;
    logic [Q_W-1:0] green;
    logic [Q_W-1:0] blue;
    logic [Q_W-1:0] alpha;
  } entry_t;

  typedef struct packed {
    logic [Q_W-1:0] c1;
    logic [Q_W-1:0] c2;
    logic [Q_W-1:0] d;
    logic [Q_W-1:0] t;
    logic [Q_W-1:0] dt;
  } chan_in_t;

endpackage

// File: rtl/core/cmap_ram.sv
// ----------------------------------------------------------------------------
// cmap_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module cmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/cmap_chan.sv
// ----------------------------------------------------------------------------
// cmap_chan
// One colour channel: weight products, scale by 255, restoring divide by
// the breakpoint span one quotient bit a stage, saturate to eight bits.
// ----------------------------------------------------------------------------
module cmap_chan import cmap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  chan_in_t   in_data,
  output logic       out_valid,
  output logic [7:0] value
);

  logic              a_valid;
  logic [PROD_W-1:0] a_p1;
  logic [PROD_W-1:0] a_p2;
  logic [Q_W-1:0]    a_d;
  logic              b_valid;
  logic [NUM_W-1:0]  b_num;
  logic [Q_W-1:0]    b_d;

  logic              dv_valid [0:QUO_W];
  logic [DIVD_W-1:0] dv_rem   [0:QUO_W-1];
  logic [Q_W-1:0]    dv_d     [0:QUO_W-1];
  logic [QUO_W-1:0]  dv_quo   [0:QUO_W];
  logic [DIVD_W-1:0] div_sh   [0:QUO_W-1];
  logic              sub_ok   [0:QUO_W-1];

  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      div_sh[j] = DIVD_W'({dv_d[j], {Q_FRAC{1'b0}}}) << (QUO_W - 1 - j);
      sub_ok[j] = dv_rem[j] >= div_sh[j];
    end
  end

  always_ff @(posedge clk) begin
    a_p1 <= PROD_W'(in_data.c1) * PROD_W'(in_data.dt);
    a_p2 <= PROD_W'(in_data.c2) * PROD_W'(in_data.t);
    a_d  <= in_data.d;
    b_num <= NUM_W'(a_p1) + NUM_W'(a_p2);
    b_d   <= a_d;
    dv_rem[0] <= {b_num, 8'h00} - DIVD_W'(b_num);
    dv_d[0]   <= b_d;
    dv_quo[0] <= '0;
    for (int j = 0; j < QUO_W; j++) begin
      dv_quo[j+1] <= {dv_quo[j][QUO_W-2:0], sub_ok[j]};
    end
    for (int j = 0; j < QUO_W - 1; j++) begin
      dv_rem[j+1] <= sub_ok[j] ? dv_rem[j] - div_sh[j] : dv_rem[j];
      dv_d[j+1]   <= dv_d[j];
    end
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      for (int j = 0; j <= QUO_W; j++) begin
        dv_valid[j] <= 1'b0;
      end
    end else begin
      a_valid     <= in_valid;
      b_valid     <= a_valid;
      dv_valid[0] <= b_valid;
      for (int j = 1; j <= QUO_W; j++) begin
        dv_valid[j] <= dv_valid[j-1];
      end
    end
  end

  assign out_valid = dv_valid[QUO_W];
  assign value     = dv_quo[QUO_W][QUO_W-1] ? 8'hFF : dv_quo[QUO_W][7:0];

endmodule

// File: rtl/core/piecewise_linear_colormap_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_lookup
// Sorted RGBA breakpoint table with pipelined linear interpolation.
// ----------------------------------------------------------------------------
// One item is taken every cycle; busy stays low. A write item stores its
// entry at once and is seen by every later lookup. A lookup gives its colour
// on the output ports, with done high for one cycle, after passing through
// the search, the table read, the product and scaling stages and the
// nine-stage divider. The result cannot be held off, so take it in the
// cycle that done marks. Every entry in use must be written before a lookup
// reads it.
// ----------------------------------------------------------------------------
module piecewise_linear_colormap_lookup import cmap_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [Q_W-1:0]   level,
  input  logic [IDX_W-1:0] entry_index,
  input  logic [Q_W-1:0]   entry_position,
  input  logic [Q_W-1:0]   entry_red,
  input  logic [Q_W-1:0]   entry_green,
  input  logic [Q_W-1:0]   entry_blue,
  input  logic [Q_W-1:0]   entry_alpha,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] entry_count,
  output logic             done,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic [7:0]       alpha_out
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] n_last;
  logic [Q_W-1:0]   bp [ENTRIES];
  logic [ENTRIES-1:0] le;
  logic [ENTRIES-1:0] gtv;
  logic             accept;
  logic             write_en;
  entry_t           wr_entry;

  logic               s1_valid;
  logic [Q_W-1:0]     s1_v;
  logic [ENTRIES-1:0] s1_le;
  logic               s1_gt;
  logic               s1_over;
  logic [CNT_W-1:0]   s1_n;
  logic [ENTRIES-1:0] cand;
  logic               found;
  logic [IDX_W-1:0]   sel;
  logic [IDX_W-1:0]   idx;
  logic               plain1;

  logic             s2_valid;
  logic [Q_W-1:0]   s2_v;
  logic             s2_plain;
  entry_t           rd_a;
  entry_t           rd_b;
  entry_t           rd_hi;
  logic             plain2;
  logic [Q_W-1:0]   d2;
  logic [Q_W-1:0]   t2;
  chan_in_t         ch_r;
  chan_in_t         ch_g;
  chan_in_t         ch_b;
  chan_in_t         ch_a;
  logic [3:0]       ch_valid;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign write_en  = accept && (op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_MIN;
    end else if (cfg_valid && cfg_ready) begin
      count <= entry_count;
    end
  end

  assign n_eff  = (count < CNT_MIN) ? CNT_MIN : ((count > CNT_MAX) ? CNT_MAX : count);
  assign n_last = IDX_W'(n_eff - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (write_en) begin
      bp[entry_index] <= entry_position;
    end
  end

  assign wr_entry = '{pos: entry_position, red: entry_red, green: entry_green,
                      blue: entry_blue, alpha: entry_alpha};

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      le[k]  = bp[k] <= level;
      gtv[k] = level > bp[k];
    end
  end

  // search stage
  always_ff @(posedge clk) begin
    s1_v    <= level;
    s1_le   <= le;
    s1_gt   <= gtv[n_last];
    s1_over <= level >= Q_ONE;
    s1_n    <= n_eff;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (op == OP_LOOKUP);
    end
  end

  always_comb begin
    sel = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      cand[k] = s1_le[k] && ((CNT_W'(k) + CNT_W'(2)) <= s1_n);
      if (cand[k]) begin
        sel = IDX_W'(k);
      end
    end
    found  = |cand;
    plain1 = s1_over || s1_gt || !found;
    if (s1_over || s1_gt) begin
      idx = IDX_W'(s1_n - CNT_W'(1));
    end else if (!found) begin
      idx = '0;
    end else begin
      idx = sel;
    end
  end

  cmap_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .we     (write_en),
    .waddr  (entry_index),
    .wdata  (wr_entry),
    .raddr_a(idx),
    .raddr_b(idx + IDX_W'(1)),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  always_ff @(posedge clk) begin
    s2_v     <= s1_v;
    s2_plain <= plain1;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // span stage: a flat colour divides by a unit span and drops the upper entry
  always_comb begin
    plain2 = s2_plain || (rd_b.pos <= rd_a.pos);
    rd_hi  = plain2 ? '0 : rd_b;
    d2     = plain2 ? Q_W'(1) : rd_b.pos - rd_a.pos;
    t2     = plain2 ? '0 : s2_v - rd_a.pos;
    ch_r   = '{c1: rd_a.red,   c2: rd_hi.red,   d: d2, t: t2, dt: d2 - t2};
    ch_g   = '{c1: rd_a.green, c2: rd_hi.green, d: d2, t: t2, dt: d2 - t2};
    ch_b   = '{c1: rd_a.blue,  c2: rd_hi.blue,  d: d2, t: t2, dt: d2 - t2};
    ch_a   = '{c1: rd_a.alpha, c2: rd_hi.alpha, d: d2, t: t2, dt: d2 - t2};
  end

  cmap_chan u_red (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_data(ch_r),
    .out_valid(ch_valid[0]), .value(red_out)
  );

  cmap_chan u_green (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_data(ch_g),
    .out_valid(ch_valid[1]), .value(green_out)
  );

  cmap_chan u_blue (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_data(ch_b),
    .out_valid(ch_valid[2]), .value(blue_out)
  );

  cmap_chan u_alpha (
    .clk(clk), .rst(rst), .in_valid(s2_valid), .in_data(ch_a),
    .out_valid(ch_valid[3]), .value(alpha_out)
  );

  assign done = &ch_valid;

`ifndef ASSERT_OFF
  a_lookup_enters: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_LOOKUP) |=> s1_valid)
    else $error("lookup transfer did not enter the search stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_WRITE) |=> !s1_valid)
    else $error("write transfer entered the lookup pipeline");

  a_search_advances: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("search stage item dropped");

  a_lower_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_plain |-> rd_a.pos <= s2_v)
    else $error("selected lower breakpoint lies above the level");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    ch_valid == 4'h0 || ch_valid == 4'hF)
    else $error("colour lanes out of step");
`endif

endmodule
